@@ hdl/osatb_pkg.sv @@
// Shared types and constants for the one-shot alarm timer bank.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package osatb_pkg;

  // Operation codes carried in the opcode field of an input transaction.
  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_DISARM = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Width of the alarm index fields on the ports.
  localparam int ID_WIDTH = 4;

  // At most this many expiries are reported for one tick.
  localparam int MAX_RESULTS = 16;
  localparam int REP_WIDTH   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]          opcode;
    logic [ID_WIDTH-1:0] alarm_id;
    logic [31:0]         timeout;
    logic                notify;
  } in_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] expired_id;
    logic                last_in_run;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic arm;         // write a new alarm entry
    logic disarm;      // clear the enable of one alarm
    logic walk_begin;  // reset the walk index and report count
    logic rd_issue;    // read the entry at the walk index and advance
    logic flush;       // release the held expiry as the last of the tick
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;    // walk index points at the final alarm
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/one_shot_alarm_timer_bank_top.sv @@
// Top level of the one-shot alarm timer bank.
// Depends on osatb_pkg, osatb_ctrl and osatb_datapath.
`default_nettype none

// A bank of ALARM_COUNT one-shot alarms driven by command transactions. A
// transaction is taken at a rising edge with start high and busy low. An arm
// or disarm transaction completes at that edge and busy stays low, so
// another transaction can follow at once. A tick transaction raises busy
// through the states S_WALK, S_LAST and S_FLUSH: in S_WALK the walk reads one
// alarm entry per cycle from the entry memory, which has one read and one
// write port, S_LAST finishes the last entry and S_FLUSH releases the final
// expiry. Each expiry is presented on result for exactly one cycle with
// strobe high, in increasing alarm order, and the last expiry of the tick
// carries last_in_run. The receiver cannot stall results, so it must take
// every strobe; the final expiry of a tick appears in the same cycle in which
// busy falls. A tick that expires no reporting alarm produces no result. Arm
// or disarm with an index beyond the bank, and the unused opcode, change
// nothing.
module one_shot_alarm_timer_bank_top #(
  parameter int ALARM_COUNT = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire osatb_pkg::in_t item,
  output logic                strobe,
  output osatb_pkg::out_t     result
);
  import osatb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the walk; of the item it sees only the opcode.
  osatb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the alarm entries and forms the expiry results.
  osatb_datapath #(
    .ALARM_COUNT (ALARM_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .sts    (sts),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

@@ hdl/osatb_ctrl.sv @@
// Controller state machine of the one-shot alarm timer bank.
// Depends on osatb_pkg for the command, status and input types.
`default_nettype none

module osatb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    opcode,
  input  wire osatb_pkg::sts_t sts,
  output osatb_pkg::cmd_t    cmd,
  output logic               busy
);
  import osatb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_LAST  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.arm    = (opcode == OP_ARM);
          cmd.disarm = (opcode == OP_DISARM);
          if (opcode == OP_TICK) begin
            cmd.walk_begin = 1'b1;
            state_next     = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.rd_issue = 1'b1;
        if (sts.idx_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        // The datapath finishes the final entry during this cycle.
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

`ifndef ASSERT_OFF
  a_tick_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && opcode == OP_TICK) |=> (state == S_WALK && cmd.rd_issue))
    else $error("tick transaction did not start the walk");

  a_flush_ends_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (!busy && !cmd.rd_issue))
    else $error("controller stayed busy after the flush cycle");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state is not one-hot");
`endif

endmodule

`default_nettype wire

@@ hdl/osatb_datapath.sv @@
// Datapath of the one-shot alarm timer bank: entry memory, enable bits, walk pipeline.
// Depends on osatb_pkg for the command, status and payload types.
`default_nettype none

module osatb_datapath #(
  parameter int ALARM_COUNT = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire osatb_pkg::cmd_t cmd,
  input  wire osatb_pkg::in_t  item,
  output osatb_pkg::sts_t      sts,
  output logic                 strobe,
  output osatb_pkg::out_t      result
);
  import osatb_pkg::*;

  localparam int IDX_W  = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
  localparam int WORD_W = 2 * COUNT_WIDTH + 1;

  // Entry word: notify, limit, count. Enable bits live in flops.
  logic [WORD_W-1:0]      mem [ALARM_COUNT];
  logic [ALARM_COUNT-1:0] enabled;

  logic [IDX_W-1:0]       rd_idx;
  logic [WORD_W-1:0]      rd_word;
  logic                   s1_valid;
  logic                   s1_en;
  logic [IDX_W-1:0]       s1_idx;

  logic [IDX_W-1:0]       pend_idx;
  logic                   pend_valid;
  logic [REP_WIDTH-1:0]   rep_cnt;

  logic                   s1_notify;
  logic [COUNT_WIDTH-1:0] s1_limit;
  logic [COUNT_WIDTH-1:0] s1_count;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   hit;
  logic                   report;
  logic                   arm_ok;
  logic [IDX_W-1:0]       id_addr;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [WORD_W-1:0]      wr_data;

  logic                   strobe_next;
  out_t                   result_next;

  assign id_addr  = IDX_W'(item.alarm_id);
  assign arm_ok   = (32'(item.alarm_id) < 32'(ALARM_COUNT));

  assign s1_notify = rd_word[WORD_W-1];
  assign s1_limit  = rd_word[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign s1_count  = rd_word[COUNT_WIDTH-1:0];
  assign cnt_inc   = s1_count + COUNT_WIDTH'(1);
  assign hit       = s1_valid && s1_en && (cnt_inc >= s1_limit);
  assign report    = hit && s1_notify && (rep_cnt < REP_WIDTH'(MAX_RESULTS));

  assign sts.idx_last = (rd_idx == IDX_W'(ALARM_COUNT - 1));

  // One write port: arming from the input, or the count update of the walk.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_idx;
    wr_data = {s1_notify, s1_limit, cnt_inc};
    if (cmd.arm && arm_ok) begin
      wr_en   = 1'b1;
      wr_addr = id_addr;
      wr_data = {item.notify, COUNT_WIDTH'(item.timeout), {COUNT_WIDTH{1'b0}}};
    end else if (s1_valid && s1_en && !hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_word <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else begin
      if (cmd.arm && arm_ok) begin
        enabled[id_addr] <= 1'b1;
      end else if (cmd.disarm && arm_ok) begin
        enabled[id_addr] <= 1'b0;
      end else if (hit) begin
        enabled[s1_idx] <= 1'b0;
      end
    end
  end

  // Walk index and the entry stage behind the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_issue;
      if (cmd.walk_begin) begin
        rd_idx <= '0;
      end else if (cmd.rd_issue) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      s1_idx <= rd_idx;
      s1_en  <= enabled[rd_idx];
    end
  end

  // An expiry is held back until the next one shows up or the walk ends,
  // so that the last one of a tick can be marked.
  always_comb begin
    strobe_next = 1'b0;
    result_next = '{expired_id: ID_WIDTH'(pend_idx), last_in_run: 1'b0};
    if (report && pend_valid) begin
      strobe_next = 1'b1;
    end else if (cmd.flush && pend_valid) begin
      strobe_next             = 1'b1;
      result_next.last_in_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rep_cnt    <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (cmd.walk_begin) begin
        rep_cnt <= '0;
      end else if (report) begin
        rep_cnt <= rep_cnt + REP_WIDTH'(1);
      end
      if (report) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (report) begin
      pend_idx <= s1_idx;
    end
  end

`ifndef ASSERT_OFF
  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush && pend_valid) |=> (strobe && result.last_in_run))
    else $error("held expiry was not released as the last of the tick");

  a_unmarked_has_successor: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_in_run) |-> pend_valid)
    else $error("unmarked expiry issued with no later expiry held");

  a_report_bound: assert property (@(posedge clk) disable iff (rst)
    rep_cnt <= REP_WIDTH'(MAX_RESULTS))
    else $error("more expiries reported than allowed for one tick");
`endif

endmodule

`default_nettype wire
